// File: rtl/core/ptt_pkg.sv
`default_nettype none
package ptt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [47:0] deadline_in;
    logic [47:0] period_in;
    logic [47:0] now;
  } in_t;

  typedef struct packed {
    logic [3:0] expired_id;
    logic       rearmed;
    logic       last;
  } out_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic arm;
    logic remove;
    logic tick;
    logic expire;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/ptt_cell.sv
`default_nettype none
module ptt_cell #(
  parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int CELL_ID   = 0
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire ptt_pkg::cell_cmd_t cmd,
  input  wire  [IDX_W-1:0]       target,
  input  wire  [TIME_BITS-1:0]   dl_in,
  input  wire  [TIME_BITS-1:0]   per_in,
  input  wire  [TIME_BITS-1:0]   now,
  input  wire                    c_found,
  input  wire                    c_multi,
  input  wire  [TIME_BITS-1:0]   c_dl,
  input  wire  [IDX_W-1:0]       c_id,
  output logic                   o_found,
  output logic                   o_multi,
  output logic [TIME_BITS-1:0]   o_dl,
  output logic [IDX_W-1:0]       o_id,
  output logic                   rearm
);

  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

  logic                 armed;
  logic                 pending;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] interval;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] next_dl;
  logic                 hit;

  assign hit     = (target == MY_ID);
  assign sum     = {1'b0, deadline} + {1'b0, interval};
  assign next_dl = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign rearm   = (next_dl > now);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (cmd.arm && hit) begin
        armed <= 1'b1;
      end else if (cmd.remove && hit) begin
        armed <= 1'b0;
      end else if (cmd.expire && hit) begin
        pending <= 1'b0;
        if (!rearm) armed <= 1'b0;
      end
      if (cmd.tick) begin
        pending <= armed && (deadline <= now);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm && hit) begin
      deadline <= dl_in;
      interval <= per_in;
    end else if (cmd.expire && hit && rearm) begin
      deadline <= next_dl;
    end
  end

  // running minimum travels one cell per cycle; strict less keeps lower id on ties
  always_ff @(posedge clk) begin
    o_found <= c_found || pending;
    o_multi <= c_multi || (c_found && pending);
    if (pending && (!c_found || deadline < c_dl)) begin
      o_dl <= deadline;
      o_id <= MY_ID;
    end else begin
      o_dl <= c_dl;
      o_id <= c_id;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/periodic_timer_table_top.sv
`default_nettype none
// Arm and remove leave busy low.
// A tick runs max(k,1) sweeps for k expiries: each report needs one
// sweep of the minimum search down the chain of NUM_TIMERS slot cells plus a report cycle.
// Reports come one per sweep on strobe for one cycle; the receiver cannot stall.
// Synchronous reset disarms all slots and returns the block to idle.
module periodic_timer_table_top #(
  parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = ptt_pkg::TIME_BITS_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  wire ptt_pkg::in_t item,
  output logic           strobe,
  output ptt_pkg::out_t  result
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(NUM_TIMERS - 1);

  ptt_pkg::state_t    state, state_next;
  ptt_pkg::cell_cmd_t cmd;
  logic [IDX_W-1:0]   cnt;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] now_bus;
  logic [IDX_W-1:0]   target;
  logic               accept;
  logic               id_ok;

  logic                 found_c [NUM_TIMERS+1];
  logic                 multi_c [NUM_TIMERS+1];
  logic [TIME_BITS-1:0] dl_c    [NUM_TIMERS+1];
  logic [IDX_W-1:0]     id_c    [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] rearm_v;

  assign accept  = start && !busy;
  assign id_ok   = (32'(item.timer_id) < NUM_TIMERS);
  assign now_bus = (state == ptt_pkg::ST_IDLE) ? TIME_BITS'(item.now) : now_q;

  assign found_c[0] = 1'b0;
  assign multi_c[0] = 1'b0;
  assign dl_c[0]    = '0;
  assign id_c[0]    = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    ptt_cell #(
      .TIME_BITS(TIME_BITS),
      .IDX_W    (IDX_W),
      .CELL_ID  (g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .target (target),
      .dl_in  (TIME_BITS'(item.deadline_in)),
      .per_in (TIME_BITS'(item.period_in)),
      .now    (now_bus),
      .c_found(found_c[g]),
      .c_multi(multi_c[g]),
      .c_dl   (dl_c[g]),
      .c_id   (id_c[g]),
      .o_found(found_c[g+1]),
      .o_multi(multi_c[g+1]),
      .o_dl   (dl_c[g+1]),
      .o_id   (id_c[g+1]),
      .rearm  (rearm_v[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ptt_pkg::ST_IDLE: begin
        if (accept && item.action == ptt_pkg::ACT_TICK) state_next = ptt_pkg::ST_SWEEP;
      end
      ptt_pkg::ST_SWEEP: begin
        if (cnt == LAST_CNT) state_next = ptt_pkg::ST_REPORT;
      end
      ptt_pkg::ST_REPORT: begin
        if (found_c[NUM_TIMERS] && multi_c[NUM_TIMERS]) state_next = ptt_pkg::ST_SWEEP;
        else state_next = ptt_pkg::ST_IDLE;
      end
      default: state_next = ptt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ptt_pkg::ST_IDLE);
    strobe     = (state == ptt_pkg::ST_REPORT) && found_c[NUM_TIMERS];
    cmd.arm    = accept && id_ok && (item.action == ptt_pkg::ACT_ARM);
    cmd.remove = accept && id_ok && (item.action == ptt_pkg::ACT_REMOVE);
    cmd.tick   = accept && (item.action == ptt_pkg::ACT_TICK);
    cmd.expire = strobe;
    target     = (state == ptt_pkg::ST_IDLE) ? IDX_W'(item.timer_id) : id_c[NUM_TIMERS];
    result.expired_id = 4'(id_c[NUM_TIMERS]);
    result.rearmed    = rearm_v[id_c[NUM_TIMERS]];
    result.last       = !multi_c[NUM_TIMERS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ptt_pkg::ST_SWEEP) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) now_q <= TIME_BITS'(item.now);
  end

endmodule
`default_nettype wire
